/* src/stream_type_device_map_table_defines.svh */
// Assertion macros shared by the stream type device map table sources.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef STREAM_TYPE_DEVICE_MAP_TABLE_DEFINES_SVH
`define STREAM_TYPE_DEVICE_MAP_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SDMT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdmt assertion failed");

// Next-cycle implication, disabled during reset.
`define SDMT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sdmt assertion failed");

`endif

/* src/sdmt_pkg.sv */
// Package for the stream type device map table: payload types, register map
// and sizing constants. No dependencies.
package sdmt_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;
	localparam int KEY_W = 48;
	localparam int DEV_W = 16;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [15:0] NO_DEVICE_RESET = 16'hFFFF;

	typedef enum logic {
		REQ_LOOKUP = 1'b0,
		REQ_SET    = 1'b1
	} req_kind_t;

	typedef enum logic {
		REG_NO_DEVICE_CODE = 1'b0
	} reg_index_t;

	typedef enum logic {
		STATUS_OK   = 1'b0,
		STATUS_FULL = 1'b1
	} status_t;

	typedef struct packed {
		logic [15:0] data_type;
		logic [15:0] op_type;
		logic [15:0] logical_dev;
	} key_t;

	typedef struct packed {
		logic        req_type;
		logic [15:0] dev_type;
		logic [15:0] data_type;
		logic [15:0] op_type;
		logic [15:0] logical_dev;
	} req_t;

	typedef struct packed {
		logic [15:0] found_dev_type;
		logic        status;
	} rsp_t;

	typedef struct packed {
		key_t        key;
		logic [15:0] dev;
	} entry_t;

endpackage

/* src/sdmt_if.sv */
// Valid/ready stream interfaces for the request and response channels.
// Depends on sdmt_pkg for the payload types.
interface sdmt_req_if;
	import sdmt_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sdmt_rsp_if;
	import sdmt_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* src/sdmt_store.sv */
// Entry memory of the device map table: one write port and one registered
// read port holding key and device type. Depends on sdmt_pkg.
module sdmt_store #(
	parameter int TABLE_ENTRIES = sdmt_pkg::TABLE_ENTRIES_DEF,
	parameter int IDX_W = $clog2(TABLE_ENTRIES)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_addr,
	input  sdmt_pkg::entry_t     wr_data,
	input  logic [IDX_W-1:0]     rd_addr,
	output sdmt_pkg::entry_t     rd_data
);
	import sdmt_pkg::*;

	entry_t mem [TABLE_ENTRIES];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

/* src/stream_type_device_map_table.sv */
// Stream type device map table: a request is answered after a scan of every
// entry, one entry per cycle through the single memory read port and key
// comparator, followed by the drain and resolve states; the next request is
// taken once the response is gone.
// Reset empties the table at once through per-entry valid flops and sets
// the no-device code to 0xFFFF.
`include "stream_type_device_map_table_defines.svh"

module stream_type_device_map_table #(
	parameter int TABLE_ENTRIES = sdmt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	sdmt_req_if.sink                             req,
	sdmt_rsp_if.source                           rsp,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [sdmt_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [sdmt_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [sdmt_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready
);
	import sdmt_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_SCAN    = 4'b0010,
		ST_DRAIN   = 4'b0100,
		ST_RESOLVE = 4'b1000
	} state_t;

	state_t state_q;
	logic [15:0] no_dev_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	req_t req_q;
	logic [IDX_W-1:0] idx_q;
	logic cmp_vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [15:0] hit_dev_q;
	logic free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	entry_t rd_data;
	entry_t wr_data;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	key_t req_key;
	logic in_xfer;
	logic cfg_wr;
	logic key_match;
	logic is_set;
	logic dev_is_none;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_NO_DEVICE_CODE) ? {16'h0000, no_dev_q} : '0;

	assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign in_xfer = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	assign req_key = '{data_type: req_q.data_type, op_type: req_q.op_type,
		logical_dev: req_q.logical_dev};
	assign key_match = cmp_vld_s1 && valid_q[idx_s1] && (rd_data.key == req_key);
	assign is_set = (req_q.req_type == REQ_SET);
	assign dev_is_none = (req_q.dev_type == no_dev_q);

	always_comb begin
		wr_en = 1'b0;
		wr_addr = free_idx_q;
		if (state_q == ST_RESOLVE && is_set && !dev_is_none) begin
			if (hit_q) begin
				wr_en = 1'b1;
				wr_addr = hit_idx_q;
			end else if (free_q) begin
				wr_en = 1'b1;
			end
		end
	end
	assign wr_data = '{key: req_key, dev: req_q.dev_type};

	sdmt_store #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.IDX_W(IDX_W)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(idx_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_dev_q <= NO_DEVICE_RESET;
		end else if (cfg_wr && paddr[2] == REG_NO_DEVICE_CODE) begin
			no_dev_q <= pwdata[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q <= req.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			idx_s1 <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			hit_dev_q <= '0;
			free_q <= 1'b0;
			free_idx_q <= '0;
			valid_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SCAN);
			idx_s1 <= idx_q;
			if (key_match) begin
				hit_q <= 1'b1;
				hit_idx_q <= idx_s1;
				hit_dev_q <= rd_data.dev;
			end
			if (cmp_vld_s1 && !valid_q[idx_s1] && !free_q) begin
				free_q <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_SCAN;
						idx_q <= '0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_RESOLVE;
				end
				ST_RESOLVE: begin
					state_q <= ST_IDLE;
					rsp_valid_q <= 1'b1;
					rsp_q.found_dev_type <= (!is_set && hit_q) ? hit_dev_q : no_dev_q;
					rsp_q.status <= (is_set && !hit_q && !free_q) ? STATUS_FULL : STATUS_OK;
					if (is_set) begin
						if (hit_q) begin
							if (dev_is_none) begin
								valid_q[hit_idx_q] <= 1'b0;
							end
						end else if (free_q && !dev_is_none) begin
							valid_q[free_idx_q] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SDMT_ASSERT_NEXT(a_xfer_starts_scan, in_xfer, state_q == ST_SCAN && idx_q == '0)
	`SDMT_ASSERT_NEXT(a_resolve_gives_rsp, state_q == ST_RESOLVE, rsp_valid_q)
	`SDMT_ASSERT_NOW(a_full_only_on_set, rsp_valid_q && rsp_q.status == STATUS_FULL, is_set)
	`SDMT_ASSERT_NEXT(a_scan_steps, state_q == ST_SCAN && idx_q != LAST_IDX,
		idx_q == $past(idx_q) + 1'b1)

endmodule
